### rtl/core/positional_ordered_list_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional ordered list
// Concurrent checks sampled on clk_i; removed in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

`ifndef SYNTHESIS
`define POL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("positional_ordered_list check failed");
`define POL_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("positional_ordered_list check failed");
`else
`define POL_ASSERT(label, prop)
`define POL_ASSERT_ALWAYS(label, prop)
`endif

`endif

### rtl/core/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Types and codes shared by the positional ordered list modules.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned PosW    = 8;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  localparam logic [FuncW-1:0] OpInsert = 2'd0;
  localparam logic [FuncW-1:0] OpRemove = 2'd1;
  localparam logic [FuncW-1:0] OpRead   = 2'd2;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StFull  = 2'd1;
  localparam logic [StatusW-1:0] StEmpty = 2'd2;
  localparam logic [StatusW-1:0] StRange = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0]       func;
    logic signed [PosW-1:0] position;
    logic [ValueW-1:0]      entry_value;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  result_value;
    logic [CountW-1:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic rem;
    logic pick;
  } cell_cmd_t;

endpackage

### rtl/core/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell
// One list slot. Loads the new value, its left neighbor or its right
// neighbor depending on the broadcast command and its place in the row.
// ----------------------------------------------------------------------------
module pol_cell #(
  parameter int unsigned IdxW    = 4,
  parameter int unsigned CellIdx = 0
) (
  input  logic                      clk_i,
  input  pol_pkg::cell_cmd_t        cmd_i,
  input  logic [IdxW-1:0]           idx_i,
  input  logic [pol_pkg::ValueW-1:0] value_i,
  input  logic [pol_pkg::ValueW-1:0] left_i,
  input  logic [pol_pkg::ValueW-1:0] right_i,
  output logic [pol_pkg::ValueW-1:0] slot_o,
  output logic [pol_pkg::ValueW-1:0] pick_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic [pol_pkg::ValueW-1:0] slot_q;
  logic [pol_pkg::ValueW-1:0] slot_d;
  logic                       hit;
  logic                       above;

  assign hit   = (idx_i == MyIdx);
  assign above = (MyIdx > idx_i);

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.ins) begin
      if (hit) begin
        slot_d = value_i;
      end else if (above) begin
        slot_d = left_i;
      end
    end else if (cmd_i.rem) begin
      if (hit || above) begin
        slot_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;
  assign pick_o = hit ? slot_q : '0;

endmodule

### rtl/core/pol_ctrl.sv
// ----------------------------------------------------------------------------
// pol_ctrl
// Holds the entry count, clamps the position and decodes each transaction
// into the command broadcast to the cell row and the result status.
// ----------------------------------------------------------------------------
`include "positional_ordered_list_defines.svh"

module pol_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IdxW  = 4,
  parameter int unsigned CntW  = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  pol_pkg::in_item_t           item_i,
  output pol_pkg::cell_cmd_t          cmd_o,
  output logic [IdxW-1:0]             idx_o,
  output logic [pol_pkg::StatusW-1:0] status_o,
  output logic [CntW-1:0]             fill_o
);

  localparam int unsigned CmpW = (CntW + 1 > pol_pkg::PosW + 1) ? CntW + 1 : pol_pkg::PosW + 1;

  logic [CntW-1:0]        fill_q;
  logic [CntW-1:0]        fill_d;
  logic signed [CmpW-1:0] pos_s;
  logic [CmpW-1:0]        lim;
  logic [CmpW-1:0]        clamped;
  logic                   empty;
  logic                   full;

  assign empty = (fill_q == '0);
  assign full  = (fill_q == CntW'(DEPTH));

  always_comb begin
    pos_s = CmpW'(item_i.position);
    lim   = CmpW'(DEPTH);
    if (item_i.func == pol_pkg::OpRead) begin
      pos_s = pos_s - CmpW'(1);
    end else if (item_i.func == pol_pkg::OpRemove) begin
      lim = CmpW'(fill_q - CntW'(1));
    end else begin
      lim = CmpW'(fill_q);
    end

    if (pos_s[CmpW-1] || (pos_s == '0)) begin
      clamped = '0;
    end else if ($unsigned(pos_s) > lim) begin
      clamped = lim;
    end else begin
      clamped = $unsigned(pos_s);
    end
  end

  always_comb begin
    cmd_o    = '0;
    status_o = pol_pkg::StOk;
    fill_d   = fill_q;
    unique case (item_i.func)
      pol_pkg::OpInsert: begin
        if (full) begin
          status_o = pol_pkg::StFull;
        end else begin
          cmd_o.ins = accept_i;
          fill_d    = fill_q + CntW'(1);
        end
      end
      pol_pkg::OpRemove: begin
        if (empty) begin
          status_o = pol_pkg::StEmpty;
        end else begin
          cmd_o.rem  = accept_i;
          cmd_o.pick = 1'b1;
          fill_d     = fill_q - CntW'(1);
        end
      end
      pol_pkg::OpRead: begin
        if (clamped >= CmpW'(fill_q)) begin
          status_o = pol_pkg::StRange;
        end else begin
          cmd_o.pick = 1'b1;
        end
      end
      default: begin
        status_o = pol_pkg::StOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept_i) begin
      fill_q <= fill_d;
    end
  end

  assign idx_o  = clamped[IdxW-1:0];
  assign fill_o = fill_d;

  `POL_ASSERT(fill_bounded_a, fill_q <= CntW'(DEPTH))
  `POL_ASSERT(insert_grows_a, cmd_o.ins |=> fill_q == $past(fill_q) + CntW'(1))
  `POL_ASSERT(remove_shrinks_a, cmd_o.rem |=> fill_q == $past(fill_q) - CntW'(1))
  `POL_ASSERT(no_insert_when_full_a, cmd_o.ins |-> !full)
  `POL_ASSERT_ALWAYS(remove_returns_a, cmd_o.rem |-> (cmd_o.pick && !cmd_o.ins))

endmodule

### rtl/core/positional_ordered_list.sv
// A result is presented in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless out_stall_i holds a result; the
// whole cell row shifts at once and the output register frees when taken.
// Reset clears the entry count and the output valid; slot contents are left
// undefined and are never read before being written.
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list with insert, remove and read at a clamped position,
// built as a row of slot cells driven by a shared controller.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pol_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pol_pkg::out_item_t out_data_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  pol_pkg::cell_cmd_t          cmd;
  logic [IdxW-1:0]             idx;
  logic [pol_pkg::StatusW-1:0] status;
  logic [CntW-1:0]             fill_next;
  logic                        accept;

  logic [pol_pkg::ValueW-1:0] slot_w [DEPTH];
  logic [pol_pkg::ValueW-1:0] pick_w [DEPTH];
  logic [pol_pkg::ValueW-1:0] picked;

  logic               out_valid_q;
  logic               out_valid_d;
  pol_pkg::out_item_t out_q;
  pol_pkg::out_item_t out_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  pol_ctrl #(
    .DEPTH (DEPTH),
    .IdxW  (IdxW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .cmd_o    (cmd),
    .idx_o    (idx),
    .status_o (status),
    .fill_o   (fill_next)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [pol_pkg::ValueW-1:0] left;
    logic [pol_pkg::ValueW-1:0] right;

    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = slot_w[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right = slot_w[k];
    end else begin : g_mid_r
      assign right = slot_w[k+1];
    end

    pol_cell #(
      .IdxW    (IdxW),
      .CellIdx (k)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (idx),
      .value_i (in_data_i.entry_value),
      .left_i  (left),
      .right_i (right),
      .slot_o  (slot_w[k]),
      .pick_o  (pick_w[k])
    );
  end

  always_comb begin
    picked = '0;
    for (int k = 0; k < DEPTH; k++) begin
      picked = picked | pick_w[k];
    end
  end

  always_comb begin
    out_d.status       = status;
    out_d.result_value = cmd.pick ? picked : '0;
    out_d.entry_count  = pol_pkg::CountW'(fill_next);
    out_valid_d        = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### verif/tb_positional_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_ordered_list
// Drives insert, remove, read and unused operations into the ordered list.
// Both handshake sides idle at random. Every result is checked against a
// shadow list kept in the testbench.
// ----------------------------------------------------------------------------
module tb_positional_ordered_list;

  localparam int ListDepth = 16;
  localparam logic [pol_pkg::FuncW-1:0] OpNone = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  pol_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  pol_pkg::out_item_t out_data_o;

  positional_ordered_list #(
    .DEPTH(ListDepth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [pol_pkg::ValueW-1:0] list_slots [ListDepth];
  int                         list_fill = 0;
  int                         peak_fill = 0;
  pol_pkg::out_item_t         expected_results [$];

  int err_count  = 0;
  int src_pct    = 0;
  int sink_pct   = 0;
  int stall_left = 0;
  int issue_fill = 0;
  int op_count     [4] = '{default: 0};
  int status_count [4] = '{default: 0};

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic int clamp_index(int pos, int hi);
    if (pos <= 0) return 0;
    if (pos > hi) return hi;
    return pos;
  endfunction

  function automatic pol_pkg::out_item_t predict_list_op(pol_pkg::in_item_t item);
    pol_pkg::out_item_t res;
    int pos;
    int idx;
    res = '0;
    res.status = pol_pkg::StOk;
    pos = $signed(item.position);
    case (item.func)
      pol_pkg::OpInsert: begin
        if (list_fill >= ListDepth) begin
          res.status = pol_pkg::StFull;
        end else begin
          idx = clamp_index(pos, list_fill);
          for (int k = list_fill; k > idx; k--) list_slots[k] = list_slots[k-1];
          list_slots[idx] = item.entry_value;
          list_fill++;
        end
      end
      pol_pkg::OpRemove: begin
        if (list_fill == 0) begin
          res.status = pol_pkg::StEmpty;
        end else begin
          idx = clamp_index(pos, list_fill - 1);
          res.result_value = list_slots[idx];
          for (int k = idx; k + 1 < list_fill; k++) list_slots[k] = list_slots[k+1];
          list_fill--;
        end
      end
      pol_pkg::OpRead: begin
        idx = clamp_index(pos - 1, ListDepth);
        if (idx >= list_fill) res.status = pol_pkg::StRange;
        else res.result_value = list_slots[idx];
      end
      default: begin
      end
    endcase
    res.entry_count = pol_pkg::CountW'(list_fill);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("ERROR at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, exp_v, got_v);
    err_count++;
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (rst_ni === 1'b1 && $urandom_range(99) < sink_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= pick_gap() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_check
    pol_pkg::out_item_t exp_res;
    if (rst_ni === 1'b1) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_list_op(in_data_i));
        op_count[in_data_i.func]++;
        if (list_fill > peak_fill) peak_fill = list_fill;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'h0, 32'(out_data_o));
        end else begin
          exp_res = expected_results.pop_front();
          status_count[exp_res.status]++;
          if (out_data_o.status !== exp_res.status)
            report_mismatch("status", 32'(exp_res.status), 32'(out_data_o.status));
          if (out_data_o.result_value !== exp_res.result_value)
            report_mismatch("result_value", 32'(exp_res.result_value),
                            32'(out_data_o.result_value));
          if (out_data_o.entry_count !== exp_res.entry_count)
            report_mismatch("entry_count", 32'(exp_res.entry_count),
                            32'(out_data_o.entry_count));
        end
      end
    end
  end

  task automatic send_item(pol_pkg::in_item_t item);
    int gap;
    gap = ($urandom_range(99) < src_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    case (item.func)
      pol_pkg::OpInsert: if (issue_fill < ListDepth) issue_fill++;
      pol_pkg::OpRemove: if (issue_fill > 0) issue_fill--;
      default: begin
      end
    endcase
  endtask

  task automatic send_op(logic [pol_pkg::FuncW-1:0] func, int pos,
                         logic [pol_pkg::ValueW-1:0] value);
    pol_pkg::in_item_t item;
    item.func        = func;
    item.position    = pol_pkg::PosW'(pos);
    item.entry_value = value;
    send_item(item);
  endtask

  task automatic wait_results_drained(int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    src_pct  = 0;
    sink_pct = 0;
    send_op(pol_pkg::OpRead,   1,    16'h0000);
    send_op(pol_pkg::OpRemove, 0,    16'h0000);
    send_op(OpNone,            0,    16'h0000);
    send_op(pol_pkg::OpInsert, -128, 16'hFFFF);
    send_op(pol_pkg::OpInsert, 127,  16'h0000);
    send_op(pol_pkg::OpInsert, 1,    16'h5555);
    send_op(pol_pkg::OpInsert, 0,    16'hAAAA);
    send_op(pol_pkg::OpRead,   -128, 16'hFFFF);
    send_op(pol_pkg::OpRead,   0,    16'h0000);
    send_op(pol_pkg::OpRead,   4,    16'h0000);
    send_op(pol_pkg::OpRead,   5,    16'h0000);
    send_op(pol_pkg::OpRead,   127,  16'h0000);
    send_op(pol_pkg::OpRemove, 127,  16'hFFFF);
    send_op(pol_pkg::OpRemove, -1,   16'h0000);
    send_op(pol_pkg::OpInsert, 2,    16'h1234);
    send_op(OpNone,            127,  16'hFFFF);
    send_op(pol_pkg::OpRemove, 1,    16'h0000);
    send_op(pol_pkg::OpRemove, 0,    16'h0000);
    send_op(pol_pkg::OpRemove, 0,    16'h0000);
    send_op(pol_pkg::OpRemove, 0,    16'h0000);
    send_op(pol_pkg::OpRead,   -128, 16'h0000);
    wait_results_drained(4);
  endtask

  task automatic test_fill_and_drain();
    src_pct  = 20;
    sink_pct = 20;
    while (issue_fill < ListDepth)
      send_op(pol_pkg::OpInsert, $urandom_range(0, issue_fill), 16'($urandom));
    send_op(pol_pkg::OpInsert, -128, 16'($urandom));
    send_op(pol_pkg::OpInsert, 127,  16'hFFFF);
    send_op(pol_pkg::OpRead,   16,   16'h0000);
    send_op(pol_pkg::OpRead,   17,   16'h0000);
    send_op(pol_pkg::OpRead,   -128, 16'h0000);
    send_op(OpNone,            -1,   16'($urandom));
    while (issue_fill > 0)
      send_op(pol_pkg::OpRemove, $urandom_range(0, issue_fill + 1) - 1, 16'($urandom));
    send_op(pol_pkg::OpRemove, 127, 16'h0000);
    wait_results_drained(4);
  endtask

  function automatic pol_pkg::in_item_t gen_list_item(bit growing);
    pol_pkg::in_item_t item;
    int r;
    r = $urandom_range(99);
    if (r < 3) item.func = OpNone;
    else if (r < (growing ? 60 : 23)) item.func = pol_pkg::OpInsert;
    else if (r < 83) item.func = pol_pkg::OpRemove;
    else item.func = pol_pkg::OpRead;
    if ($urandom_range(99) < 80)
      item.position = pol_pkg::PosW'($urandom_range(0, issue_fill + 4) - 2);
    else item.position = pol_pkg::PosW'($urandom);
    r = $urandom_range(99);
    if (r < 5) item.entry_value = '0;
    else if (r < 10) item.entry_value = '1;
    else item.entry_value = pol_pkg::ValueW'($urandom);
    return item;
  endfunction

  task automatic test_random_ops(int n_items, int src_level, int sink_level);
    bit growing;
    growing  = 1'b1;
    src_pct  = src_level;
    sink_pct = sink_level;
    for (int i = 0; i < n_items; i++) begin
      if (issue_fill >= ListDepth) growing = 1'b0;
      else if (issue_fill == 0) growing = 1'b1;
      else if ($urandom_range(99) < 3) growing = !growing;
      send_item(gen_list_item(growing));
    end
  endtask

  task automatic test_pause_mid_stream();
    test_random_ops(200, 40, 40);
    wait_results_drained(3);
    test_random_ops(200, 40, 40);
    wait_results_drained(4);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_fill_and_drain();
    test_random_ops(300, 0, 0);
    test_random_ops(600, 30, 30);
    test_random_ops(300, 60, 60);
    test_pause_mid_stream();

    wait_results_drained(10);
    if (expected_results.size() != 0)
      report_mismatch("results still outstanding", 0, expected_results.size());
    $display("Sent insert %0d, remove %0d, read %0d, unused %0d; peak fill %0d of %0d.",
             op_count[pol_pkg::OpInsert], op_count[pol_pkg::OpRemove],
             op_count[pol_pkg::OpRead], op_count[OpNone], peak_fill, ListDepth);
    $display("Checked status ok %0d, full %0d, empty %0d, out of range %0d; %0d errors.",
             status_count[pol_pkg::StOk], status_count[pol_pkg::StFull],
             status_count[pol_pkg::StEmpty], status_count[pol_pkg::StRange], err_count);
    if (err_count == 0) begin
      $display("positional_ordered_list test passed");
    end else begin
      $display("positional_ordered_list test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("positional_ordered_list test failed");
    $finish;
  end

endmodule
